// File: rtl/core/wfwh_pkg.sv
// Shared types and constants for the weighted fixed-width histogram core.
package wfwh_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_LOW_EDGE      = 3'd0;
    localparam logic [2:0] REG_HIGH_EDGE     = 3'd1;
    localparam logic [2:0] REG_BIN_COUNT     = 3'd2;
    localparam logic [2:0] REG_SCALE         = 3'd3;
    localparam logic [2:0] REG_KEEP_OVERFLOW = 3'd4;
    localparam logic [2:0] REG_USE_WEIGHTS   = 3'd5;

    // Request types
    localparam logic REQ_ACCUM = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // Field widths
    localparam int SAMPLE_W = 32;
    localparam int WEIGHT_W = 16;
    localparam int RIDX_W   = 10;
    localparam int COUNT_W  = 11;
    localparam int SUM_W    = 48;
    localparam int SQW_W    = 2 * WEIGHT_W;

    // Unit weight in Q8.8
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_ONE = 16'sd256;

    // Reset values of the configuration registers
    localparam logic signed [SAMPLE_W-1:0] LOW_EDGE_RST  = 32'sd0;
    localparam logic signed [SAMPLE_W-1:0] HIGH_EDGE_RST = 32'sd1024;
    localparam logic [COUNT_W-1:0]         BIN_COUNT_RST = 11'd1024;
    localparam logic [31:0]                SCALE_RST     = 32'd65536;

    // Saturation limits
    localparam logic [SUM_W-1:0] WSUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] WSUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [SUM_W-1:0] SQSUM_MAX = {SUM_W{1'b1}};

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch an accepted request
        logic mul;       // register bin product and squared weight
        logic bin;       // register the chosen bin
        logic fetch;     // read the bin store
        logic update;    // write back the accumulated sums
        logic result;    // load the output register, clear on read
        logic clr_step;  // zero one entry of the store after reset
    } wfwh_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic drop;      // sample falls outside the range and is dropped
        logic out_free;  // output register can take a result this cycle
        logic clr_last;  // clearing pass is at its last entry
    } wfwh_status_t;

endpackage

// File: rtl/core/wfwh_ctrl.sv
// Controller state machine of the weighted fixed-width histogram core.
module wfwh_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_req_type,
    output logic                  in_stall,
    input  wfwh_pkg::wfwh_status_t status,
    output wfwh_pkg::wfwh_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_BIN,
        S_AFETCH,
        S_UPDATE,
        S_RFETCH,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Requests are taken only while idle
    assign in_stall = (state_reg != S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (in_req_type == wfwh_pkg::REQ_READ) ? S_RFETCH : S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_BIN;
            end
            S_BIN:
            begin
                cmd.bin    = 1'b1;
                state_next = status.drop ? S_IDLE : S_AFETCH;
            end
            S_AFETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_IDLE;
            end
            S_RFETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.result = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/wfwh_dp.sv
// Datapath of the weighted fixed-width histogram core: config, binning, bin store.
module wfwh_dp #(
    parameter int MAX_BINS = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration port
    input  logic                                   cfg_write,
    input  logic [2:0]                             cfg_index,
    input  logic [31:0]                            cfg_data,
    // request payload
    input  logic                                   req_type,
    input  logic signed [wfwh_pkg::SAMPLE_W-1:0]   sample,
    input  logic signed [wfwh_pkg::WEIGHT_W-1:0]   weight,
    input  logic [wfwh_pkg::RIDX_W-1:0]            read_index,
    input  logic                                   clear_after_read,
    // result channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [wfwh_pkg::RIDX_W-1:0]            bin_number,
    output logic signed [wfwh_pkg::SUM_W-1:0]      weight_sum,
    output logic [wfwh_pkg::SUM_W-1:0]             square_sum,
    output logic                                   index_invalid,
    // controller link
    input  wfwh_pkg::wfwh_cmd_t                    cmd,
    output wfwh_pkg::wfwh_status_t                 status
);

    localparam int IDX_W   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_W   = ($clog2(MAX_BINS + 1) > wfwh_pkg::COUNT_W) ?
                             $clog2(MAX_BINS + 1) : wfwh_pkg::COUNT_W;
    localparam int SUM_W   = wfwh_pkg::SUM_W;
    localparam int ENTRY_W = 2 * SUM_W;
    localparam int PROD_W  = 64;
    localparam int FRAC_W  = 16;

    // Configuration registers
    logic signed [31:0]               low_edge_reg;
    logic signed [31:0]               high_edge_reg;
    logic [wfwh_pkg::COUNT_W-1:0]     bin_count_reg;
    logic [31:0]                      scale_reg;
    logic                             keep_overflow_reg;
    logic                             use_weights_reg;

    // Captured request
    logic                             req_read_reg;
    logic [31:0]                      diff_reg;
    logic                             below_reg;
    logic                             above_reg;
    logic signed [wfwh_pkg::WEIGHT_W-1:0] w_reg;
    logic [wfwh_pkg::RIDX_W-1:0]      ri_reg;
    logic                             clr_reg;

    // Binning pipeline
    logic signed [wfwh_pkg::SQW_W-1:0] w_ext;
    logic [PROD_W-1:0]                prod_reg;
    logic [wfwh_pkg::SQW_W-1:0]       wsq_reg;
    logic [IDX_W-1:0]                 bin_reg;
    logic [IDX_W-1:0]                 bin_next;
    logic                             drop;

    // Bin store
    logic [ENTRY_W-1:0]               bin_mem [MAX_BINS];
    logic [ENTRY_W-1:0]               rdata_reg;
    logic [IDX_W-1:0]                 raddr;
    logic                             mem_we;
    logic [IDX_W-1:0]                 mem_waddr;
    logic [ENTRY_W-1:0]               mem_wdata;
    logic [IDX_W-1:0]                 clr_cnt_reg;

    // Output register
    logic                             out_valid_reg;
    logic [wfwh_pkg::RIDX_W-1:0]      bin_number_reg;
    logic [SUM_W-1:0]                 weight_sum_reg;
    logic [SUM_W-1:0]                 square_sum_reg;
    logic                             index_invalid_reg;

    // Derived values
    logic [CNT_W-1:0]                 bc_ext;
    logic [CNT_W-1:0]                 n_use;
    logic [IDX_W-1:0]                 last_bin;
    logic [SUM_W-1:0]                 idx;
    logic                             ri_invalid;
    logic [SUM_W-1:0]                 cur_wsum;
    logic [SUM_W-1:0]                 cur_sqsum;
    logic [SUM_W:0]                   wsum_wide;
    logic [SUM_W:0]                   sqsum_wide;
    logic [SUM_W-1:0]                 wsum_sat;
    logic [SUM_W-1:0]                 sqsum_sat;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_edge_reg      <= wfwh_pkg::LOW_EDGE_RST;
            high_edge_reg     <= wfwh_pkg::HIGH_EDGE_RST;
            bin_count_reg     <= wfwh_pkg::BIN_COUNT_RST;
            scale_reg         <= wfwh_pkg::SCALE_RST;
            keep_overflow_reg <= 1'b0;
            use_weights_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                wfwh_pkg::REG_LOW_EDGE:      low_edge_reg      <= $signed(cfg_data);
                wfwh_pkg::REG_HIGH_EDGE:     high_edge_reg     <= $signed(cfg_data);
                wfwh_pkg::REG_BIN_COUNT:     bin_count_reg     <= cfg_data[wfwh_pkg::COUNT_W-1:0];
                wfwh_pkg::REG_SCALE:         scale_reg         <= cfg_data;
                wfwh_pkg::REG_KEEP_OVERFLOW: keep_overflow_reg <= cfg_data[0];
                wfwh_pkg::REG_USE_WEIGHTS:   use_weights_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Bins in use: zero reads as one, clamp to the store depth
    always_comb
    begin
        bc_ext = CNT_W'(bin_count_reg);
        if (bc_ext == '0)
        begin
            n_use = CNT_W'(1);
        end
        else if (bc_ext > CNT_W'(MAX_BINS))
        begin
            n_use = CNT_W'(MAX_BINS);
        end
        else
        begin
            n_use = bc_ext;
        end
    end

    assign last_bin   = IDX_W'(n_use - CNT_W'(1));
    assign ri_invalid = (CNT_W'(ri_reg) >= n_use);

    // Capture request, range checks and offset
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_read_reg <= (req_type == wfwh_pkg::REQ_READ);
            diff_reg     <= 32'(sample - low_edge_reg);
            below_reg    <= (sample < low_edge_reg);
            above_reg    <= (sample >= high_edge_reg);
            w_reg        <= use_weights_reg ? weight : wfwh_pkg::WEIGHT_ONE;
            ri_reg       <= read_index;
            clr_reg      <= clear_after_read;
        end
    end

    // Weight sign-extended to the square width before squaring
    assign w_ext = wfwh_pkg::SQW_W'(w_reg);

    // Bin product and squared weight
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(diff_reg) * PROD_W'(scale_reg);
            wsq_reg  <= wfwh_pkg::SQW_W'(w_ext * w_ext);
        end
    end

    // Bin selection with clamping and drop
    assign idx = prod_reg[PROD_W-1:FRAC_W];

    always_comb
    begin
        drop     = 1'b0;
        bin_next = '0;
        if (below_reg)
        begin
            drop     = !keep_overflow_reg;
            bin_next = '0;
        end
        else if (above_reg)
        begin
            drop     = !keep_overflow_reg;
            bin_next = last_bin;
        end
        else if (idx >= SUM_W'(n_use))
        begin
            bin_next = last_bin;
        end
        else
        begin
            bin_next = idx[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bin)
        begin
            bin_reg <= bin_next;
        end
    end

    // Saturating accumulate
    assign cur_wsum   = rdata_reg[ENTRY_W-1:SUM_W];
    assign cur_sqsum  = rdata_reg[SUM_W-1:0];
    assign wsum_wide  = {cur_wsum[SUM_W-1], cur_wsum}
                      + {{(SUM_W + 1 - wfwh_pkg::WEIGHT_W){w_reg[wfwh_pkg::WEIGHT_W-1]}}, w_reg};
    assign sqsum_wide = {1'b0, cur_sqsum} + {{(SUM_W + 1 - wfwh_pkg::SQW_W){1'b0}}, wsq_reg};

    always_comb
    begin
        if (wsum_wide[SUM_W] != wsum_wide[SUM_W-1])
        begin
            wsum_sat = wsum_wide[SUM_W] ? wfwh_pkg::WSUM_MIN : wfwh_pkg::WSUM_MAX;
        end
        else
        begin
            wsum_sat = wsum_wide[SUM_W-1:0];
        end
        sqsum_sat = sqsum_wide[SUM_W] ? wfwh_pkg::SQSUM_MAX : sqsum_wide[SUM_W-1:0];
    end

    // Store write port: clearing pass, accumulate, clear on read
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = bin_reg;
        mem_wdata = '0;
        if (cmd.clr_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
        end
        else if (cmd.update)
        begin
            mem_we    = 1'b1;
            mem_waddr = bin_reg;
            mem_wdata = {wsum_sat, sqsum_sat};
        end
        else if (cmd.result)
        begin
            mem_we    = !ri_invalid && clr_reg;
            mem_waddr = IDX_W'(ri_reg);
        end
    end

    assign raddr = req_read_reg ? IDX_W'(ri_reg) : bin_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bin_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            rdata_reg <= bin_mem[raddr];
        end
    end

    // Clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.result)
        begin
            bin_number_reg    <= ri_reg;
            index_invalid_reg <= ri_invalid;
            weight_sum_reg    <= ri_invalid ? '0 : cur_wsum;
            square_sum_reg    <= ri_invalid ? '0 : cur_sqsum;
        end
    end

    assign out_valid     = out_valid_reg;
    assign bin_number    = bin_number_reg;
    assign weight_sum    = $signed(weight_sum_reg);
    assign square_sum    = square_sum_reg;
    assign index_invalid = index_invalid_reg;

    // Status back to the controller
    assign status.drop     = drop;
    assign status.out_free = !out_valid_reg || !out_stall;
    assign status.clr_last = (clr_cnt_reg == IDX_W'(MAX_BINS - 1));

endmodule

// File: rtl/core/weighted_fixed_width_histogram_core.sv
// Top level of the weighted fixed-width histogram core.
//
//  channel   direction  handshake             payload
//  cfg       in         cfg_write             cfg_index, cfg_data
//  in        in         in_valid / in_stall   req_type, sample, weight, read_index,
//                                             clear_after_read
//  out       out        out_valid / out_stall bin_number, weight_sum, square_sum,
//                                             index_invalid
//
// One request at a time. An accumulate request steps through offset, 32x32 bin
// multiply, bin select, store read and saturating write-back before the next accept;
// a dropped sample returns to idle after bin select. A read request steps through
// store read and result load, plus any wait for the output register to free up.
// After reset a clearing pass zeroes every entry of the bin store; in_stall
// stays high during it. Configuration writes are taken at any time.
// A result waits in the output register under out_stall while the next request runs.
module weighted_fixed_width_histogram_core #(
    parameter int MAX_BINS = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration port
    input  logic                                 cfg_write,
    input  logic [2:0]                           cfg_index,
    input  logic [31:0]                          cfg_data,
    // request channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 req_type,
    input  logic signed [wfwh_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [wfwh_pkg::WEIGHT_W-1:0] weight,
    input  logic [wfwh_pkg::RIDX_W-1:0]          read_index,
    input  logic                                 clear_after_read,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [wfwh_pkg::RIDX_W-1:0]          bin_number,
    output logic signed [wfwh_pkg::SUM_W-1:0]    weight_sum,
    output logic [wfwh_pkg::SUM_W-1:0]           square_sum,
    output logic                                 index_invalid
);

    wfwh_pkg::wfwh_cmd_t    cmd;
    wfwh_pkg::wfwh_status_t status;

    // Sequencer
    wfwh_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_req_type (req_type),
        .in_stall    (in_stall),
        .status      (status),
        .cmd         (cmd)
    );

    // Binning, bin store and output register
    wfwh_dp #(
        .MAX_BINS (MAX_BINS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_type         (req_type),
        .sample           (sample),
        .weight           (weight),
        .read_index       (read_index),
        .clear_after_read (clear_after_read),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .bin_number       (bin_number),
        .weight_sum       (weight_sum),
        .square_sum       (square_sum),
        .index_invalid    (index_invalid),
        .cmd              (cmd),
        .status           (status)
    );

endmodule
